// ===== design/bvl2_pkg.sv =====
// ----------------------------------------------------------------------------
// bvl2_pkg
// Shared types and constants for the byte vector L2 distance block.
// ----------------------------------------------------------------------------
package bvl2_pkg;

  localparam int unsigned SumW    = 24;
  localparam int unsigned DistW   = 20;
  localparam int unsigned RadW    = 40;   // root operand: sum << 16
  localparam int unsigned RootSteps = 20;
  localparam int unsigned IterW   = 5;
  localparam logic [IterW-1:0] IterLast = IterW'(RootSteps - 1);

  typedef enum logic [1:0] {
    RT_IDLE,
    RT_RUN,
    RT_WAIT
  } root_state_t;

  // controller to datapath
  typedef struct packed {
    logic acc_en;      // accept a byte pair into the accumulator
    logic acc_last;    // accepted pair closes the digest
    logic root_step;   // one iteration of the square root
    logic load_out;    // move root result to the output register
  } dp_cmd_t;

endpackage

// ===== design/bvl2_ctrl.sv =====
// ----------------------------------------------------------------------------
// bvl2_ctrl
// Controller: input handshake, root iteration sequencing, output valid.
// ----------------------------------------------------------------------------
module bvl2_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output bvl2_pkg::dp_cmd_t cmd
);
  import bvl2_pkg::*;

  root_state_t      state, state_next;
  logic [IterW-1:0] iter, iter_next;
  logic             out_free;
  logic             in_fire;

  assign out_free = !out_valid || out_ready;
  // a closing pair needs the root unit free; other pairs always enter
  assign in_ready = (state == RT_IDLE) || !in_last;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_next = state;
    iter_next  = iter;
    case (state)
      RT_IDLE: begin
        iter_next = '0;
        if (in_fire && in_last) begin
          state_next = RT_RUN;
        end
      end
      RT_RUN: begin
        iter_next = iter + 1'b1;
        if (iter == IterLast) begin
          state_next = RT_WAIT;
        end
      end
      RT_WAIT: begin
        if (out_free) begin
          state_next = RT_IDLE;
        end
      end
      default: state_next = RT_IDLE;
    endcase
  end

  always_comb begin
    cmd.acc_en    = in_fire;
    cmd.acc_last  = in_last;
    cmd.root_step = 1'b0;
    cmd.load_out  = 1'b0;
    case (state)
      RT_RUN:  cmd.root_step = 1'b1;
      RT_WAIT: cmd.load_out  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= RT_IDLE;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/bvl2_dp.sv =====
// ----------------------------------------------------------------------------
// bvl2_dp
// Datapath: saturating sum of squared differences, bit-serial square root,
// output register.
// ----------------------------------------------------------------------------
module bvl2_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  bvl2_pkg::dp_cmd_t         cmd,
  input  logic [7:0]                byte_a,
  input  logic [7:0]                byte_b,
  output logic [bvl2_pkg::DistW-1:0] distance_q8,
  output logic [bvl2_pkg::SumW-1:0]  sum_squares,
  output logic                      overflow
);
  import bvl2_pkg::*;

  localparam logic [SumW-1:0] SumMax  = '1;
  localparam logic [RadW-1:0] BitInit = RadW'(1) << (RadW - 2);

  logic [SumW-1:0] square_sum;
  logic            saturated_flag;
  logic [7:0]      diff;
  logic [15:0]     diff_sq;
  logic [SumW:0]   total;
  logic            sat;
  logic [SumW-1:0] sum_clip;

  logic [RadW-1:0] rem, res, rbit;
  logic [SumW-1:0] root_sum;
  logic            root_flag;
  logic [RadW:0]   trial;
  logic            take;

  assign diff     = (byte_a >= byte_b) ? (byte_a - byte_b) : (byte_b - byte_a);
  assign diff_sq  = {8'b0, diff} * {8'b0, diff};
  assign total    = {1'b0, square_sum} + {{(SumW + 1 - 16){1'b0}}, diff_sq};
  assign sat      = total[SumW];
  assign sum_clip = sat ? SumMax : total[SumW-1:0];

  assign trial = {1'b0, res} + {1'b0, rbit};
  assign take  = {1'b0, rem} >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum     <= '0;
      saturated_flag <= 1'b0;
    end else if (cmd.acc_en) begin
      if (cmd.acc_last) begin
        square_sum     <= '0;
        saturated_flag <= 1'b0;
      end else begin
        square_sum     <= sum_clip;
        saturated_flag <= saturated_flag | sat;
      end
    end
  end

  // root unit: load on a closing pair, then iterate
  always_ff @(posedge clk) begin
    if (cmd.acc_en && cmd.acc_last) begin
      rem       <= {sum_clip, 16'b0};
      res       <= '0;
      rbit      <= BitInit;
      root_sum  <= sum_clip;
      root_flag <= saturated_flag | sat;
    end else if (cmd.root_step) begin
      if (take) begin
        rem <= rem - trial[RadW-1:0];
        res <= (res >> 1) + rbit;
      end else begin
        res <= res >> 1;
      end
      rbit <= rbit >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      distance_q8 <= res[DistW-1:0];
      sum_squares <= root_sum;
      overflow    <= root_flag;
    end
  end

endmodule

// ===== design/byte_vector_l2_distance.sv =====
// ----------------------------------------------------------------------------
// byte_vector_l2_distance
// Euclidean distance between two byte digests streamed one pair at a time.
// ----------------------------------------------------------------------------
// Throughput: one byte pair per cycle; a closing pair waits while the root
//   unit is busy with its iterations and the output load for the last digest.
// Result: after the closing pair is accepted, the bit-serial square root
//   iterates in RT_RUN, then RT_WAIT loads the output once it is free.
// Reset: rst (synchronous) clears the running sum, flag, controller, out_valid.
module byte_vector_l2_distance (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 byte_a,
  input  logic [7:0]                 byte_b,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bvl2_pkg::DistW-1:0] distance_q8,
  output logic [bvl2_pkg::SumW-1:0]  sum_squares,
  output logic                       overflow
);
  import bvl2_pkg::*;

  dp_cmd_t cmd;

  bvl2_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bvl2_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .byte_a      (byte_a),
    .byte_b      (byte_b),
    .distance_q8 (distance_q8),
    .sum_squares (sum_squares),
    .overflow    (overflow)
  );

endmodule
